// File: hw/rtl/jqps_pkg.sv
package jqps_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int ID_W  = 16;
  localparam int PRI_W = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FINISH = 2'd1,
    OP_SORT   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] prio;
    logic             empty;
    logic             dropped;
  } res_t;

  // ring position of the k-th queued job
  function automatic logic [IDX_W-1:0] pos_of(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(k);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// File: hw/rtl/jqps_store.sv
module jqps_store (
  input  logic                clk,
  input  jqps_pkg::mem_req_t  req,
  output jqps_pkg::entry_t    rd_data
);

  jqps_pkg::entry_t mem [jqps_pkg::DEPTH];
  jqps_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/jqps_ctrl.sv
module jqps_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [1:0]                        in_op,
  input  logic [jqps_pkg::PRI_W-1:0]        in_job_priority,
  output logic                              in_stall,
  input  logic                              out_free,
  input  jqps_pkg::entry_t                  rd_data,
  output jqps_pkg::mem_req_t                req,
  output jqps_pkg::res_t                    res
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_EMIT  = 7'b0000100,
    ST_LDA   = 7'b0001000,
    ST_LDB   = 7'b0010000,
    ST_CMP   = 7'b0100000,
    ST_WRA   = 7'b1000000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [jqps_pkg::IDX_W-1:0]       head_r, head_nxt;
  logic [jqps_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [jqps_pkg::ID_W-1:0]        next_id_r, next_id_nxt;
  jqps_pkg::entry_t                 cache_r, cache_nxt;
  jqps_pkg::entry_t                 cur_r, cur_nxt;
  logic [jqps_pkg::IDX_W-1:0]       i_r, i_nxt;
  logic [jqps_pkg::IDX_W-1:0]       j_r, j_nxt;
  logic                             accept;
  logic                             dropped;
  logic                             worse;
  logic [jqps_pkg::CNT_W-1:0]       j_inc;
  logic [jqps_pkg::CNT_W-1:0]       i_inc2;

  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign j_inc    = jqps_pkg::CNT_W'(j_r) + jqps_pkg::CNT_W'(1);
  assign i_inc2   = jqps_pkg::CNT_W'(i_r) + jqps_pkg::CNT_W'(2);

  // current holder loses to the candidate
  assign worse = (cur_r.prio < rd_data.prio) ||
                 ((cur_r.prio == rd_data.prio) && (cur_r.id > rd_data.id));

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    cache_nxt   = cache_r;
    cur_nxt     = cur_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    dropped     = 1'b0;
    res.valid   = 1'b0;
    req         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (jqps_pkg::op_t'(in_op))
            jqps_pkg::OP_ADD: begin
              res.valid = 1'b1;
              if (count_r >= jqps_pkg::CNT_W'(jqps_pkg::DEPTH)) begin
                dropped = 1'b1;
              end else begin
                req.wr_en        = 1'b1;
                req.wr_addr      = jqps_pkg::pos_of(head_r, count_r);
                req.wr_data.id   = next_id_r;
                req.wr_data.prio = in_job_priority;
                if (count_r == '0) begin
                  cache_nxt = req.wr_data;
                end
                next_id_nxt = next_id_r + jqps_pkg::ID_W'(1);
                count_nxt   = count_r + jqps_pkg::CNT_W'(1);
              end
            end
            jqps_pkg::OP_FINISH: begin
              if (count_r > jqps_pkg::CNT_W'(1)) begin
                head_nxt    = jqps_pkg::pos_of(head_r, jqps_pkg::CNT_W'(1));
                count_nxt   = count_r - jqps_pkg::CNT_W'(1);
                req.rd_en   = 1'b1;
                req.rd_addr = head_nxt;
                state_nxt   = ST_FETCH;
              end else begin
                res.valid = 1'b1;
                if (count_r != '0) begin
                  head_nxt  = jqps_pkg::pos_of(head_r, jqps_pkg::CNT_W'(1));
                  count_nxt = '0;
                end
              end
            end
            jqps_pkg::OP_SORT: begin
              if (count_r > jqps_pkg::CNT_W'(1)) begin
                i_nxt     = '0;
                state_nxt = ST_LDA;
              end else begin
                res.valid = 1'b1;
              end
            end
            jqps_pkg::OP_CLEAR: begin
              res.valid = 1'b1;
              count_nxt = '0;
              head_nxt  = '0;
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      ST_FETCH: begin
        cache_nxt = rd_data;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          res.valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LDA: begin
        req.rd_en   = 1'b1;
        req.rd_addr = jqps_pkg::pos_of(head_r, jqps_pkg::CNT_W'(i_r));
        j_nxt       = i_r + jqps_pkg::IDX_W'(1);
        state_nxt   = ST_LDB;
      end
      ST_LDB: begin
        cur_nxt     = rd_data;
        req.rd_en   = 1'b1;
        req.rd_addr = jqps_pkg::pos_of(head_r, jqps_pkg::CNT_W'(j_r));
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        if (worse) begin
          req.wr_en   = 1'b1;
          req.wr_addr = jqps_pkg::pos_of(head_r, jqps_pkg::CNT_W'(j_r));
          req.wr_data = cur_r;
          cur_nxt     = rd_data;
        end
        if (j_inc < count_r) begin
          j_nxt       = j_inc[jqps_pkg::IDX_W-1:0];
          req.rd_en   = 1'b1;
          req.rd_addr = jqps_pkg::pos_of(head_r, j_inc);
        end else begin
          state_nxt = ST_WRA;
        end
      end
      ST_WRA: begin
        req.wr_en   = 1'b1;
        req.wr_addr = jqps_pkg::pos_of(head_r, jqps_pkg::CNT_W'(i_r));
        req.wr_data = cur_r;
        // head is final once the first pass ends
        if (i_r == '0) begin
          cache_nxt = cur_r;
        end
        if (i_inc2 < count_r) begin
          i_nxt     = i_r + jqps_pkg::IDX_W'(1);
          state_nxt = ST_LDA;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.count   = count_nxt;
    res.empty   = (count_nxt == '0);
    res.id      = res.empty ? '0 : cache_nxt.id;
    res.prio    = res.empty ? '0 : cache_nxt.prio;
    res.dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      next_id_r <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cache_r <= cache_nxt;
    cur_r   <= cur_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
  end

endmodule

// File: hw/rtl/job_queue_priority_sort.sv
// bounded job queue with in-place priority sort
// input channel: in_valid / in_stall carry in_op and in_job_priority; a
//   transaction completes on a clock edge with in_valid high and in_stall low
// result channel: out_valid / out_stall carry out_job_count, out_head_id,
//   out_head_priority, out_is_empty and out_dropped, one result per input
// add, clear, sort of fewer than two jobs and finish leaving no job: the
//   result is valid in the next cycle; one per cycle without out_stall
// finish leaving one or more jobs: via ST_FETCH and ST_EMIT, set by the
//   registered read of the new head from the job store
// sort of n jobs: ST_LDA, ST_LDB, ST_CMP, ST_WRA passes, one compare per
//   cycle through the single read and write port of the job store
// in_stall stays high while an item is at work
// reset: queue empty, head at slot zero, identifier counter at zero; the
//   job store itself is not cleared and needs no clearing pass
// receiver stall: the result holds in the output register; a new item is
//   taken only when that register is empty or being emptied in that cycle
module job_queue_priority_sort (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic [jqps_pkg::PRI_W-1:0]         in_job_priority,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [jqps_pkg::CNT_W-1:0]         out_job_count,
  output logic [jqps_pkg::ID_W-1:0]          out_head_id,
  output logic [jqps_pkg::PRI_W-1:0]         out_head_priority,
  output logic                               out_is_empty,
  output logic                               out_dropped
);

  jqps_pkg::mem_req_t req;
  jqps_pkg::entry_t   rd_data;
  jqps_pkg::res_t     res;
  jqps_pkg::res_t     out_r;
  logic               out_valid_r;
  logic               out_free;

  assign out_free = !out_valid_r || !out_stall;

  jqps_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_op           (in_op),
    .in_job_priority (in_job_priority),
    .in_stall        (in_stall),
    .out_free        (out_free),
    .rd_data         (rd_data),
    .req             (req),
    .res             (res)
  );

  jqps_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_job_count     = out_r.count;
  assign out_head_id       = out_r.id;
  assign out_head_priority = out_r.prio;
  assign out_is_empty      = out_r.empty;
  assign out_dropped       = out_r.dropped;

endmodule

// File: hw/rtl/jqps_checker.sv
module jqps_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [1:0]                         in_op,
  input logic [jqps_pkg::PRI_W-1:0]         in_job_priority,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [jqps_pkg::CNT_W-1:0]         out_job_count,
  input logic [jqps_pkg::ID_W-1:0]          out_head_id,
  input logic [jqps_pkg::PRI_W-1:0]         out_head_priority,
  input logic                               out_is_empty,
  input logic                               out_dropped
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_job_count) &&
      $stable(out_head_id) && $stable(out_head_priority) &&
      $stable(out_is_empty) && $stable(out_dropped))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_job_count == '0)) &&
      (out_job_count <= jqps_pkg::CNT_W'(jqps_pkg::DEPTH)))
    else $error("count and empty flag disagree");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_head_id == '0 && out_head_priority == '0)
    else $error("empty queue shows a head job");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_job_count == jqps_pkg::CNT_W'(jqps_pkg::DEPTH))
    else $error("job dropped while queue not full");

endmodule

bind job_queue_priority_sort jqps_checker u_jqps_checker (.*);
